[design/ffea_pkg.sv]
// Shared types and constants for the first-fit extent allocator.
// No dependencies; imported by every other design file.
package ffea_pkg;

    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int END_W   = 14;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] CFG_POOL_BLOCKS = 2'd0;
    localparam logic [1:0] CFG_PHYS_BASE   = 2'd1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SHRINK,
        OP_REMOVE,
        OP_MERGE_BOTH,
        OP_MERGE_BELOW,
        OP_MERGE_ABOVE,
        OP_INSERT
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DEC,
        S_UPD
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_ent;

    typedef struct packed {
        logic [START_W-1:0] a;
        logic [LEN_W-1:0]   size;
        logic [END_W-1:0]   e;
    } t_req;

    typedef struct packed {
        logic valid;
        logic ge;
        logic eqlen;
        logic lt;
        logic endeq;
        logic steq;
        logic ovl;
    } t_flags;

endpackage

[design/ffea_cell.sv]
// One slot of the sorted free-extent row: holds one extent, compares it
// against the current request and shifts to or from its neighbors.
// Depends on ffea_pkg.
module ffea_cell #(
    parameter bit P_FIRST = 1'b0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_init,
    input  logic [ffea_pkg::LEN_W-1:0]  i_init_len,
    input  logic                        i_cmp,
    input  ffea_pkg::t_req              i_req,
    input  ffea_pkg::t_op               i_op,
    input  logic                        i_tgt,
    input  logic                        i_mask,
    input  ffea_pkg::t_ent              i_lo,
    input  ffea_pkg::t_ent              i_hi,
    output ffea_pkg::t_ent              o_ent,
    output ffea_pkg::t_flags            o_flags,
    output logic [ffea_pkg::START_W-1:0] o_cand
);
    import ffea_pkg::*;

    t_ent               r_ent, n_ent;
    t_flags             r_flags, n_flags;
    logic [START_W-1:0] r_cand, n_cand;
    logic [END_W-1:0]   w_end;

    assign w_end = END_W'(r_ent.len) + END_W'(r_ent.start);

    always_comb begin
        n_flags.valid = r_ent.valid;
        n_flags.ge    = r_ent.valid && (r_ent.len >= i_req.size);
        n_flags.eqlen = r_ent.valid && (r_ent.len == i_req.size);
        n_flags.lt    = r_ent.valid && (r_ent.start < i_req.a);
        n_flags.endeq = r_ent.valid && (w_end == END_W'(i_req.a));
        n_flags.steq  = r_ent.valid && (END_W'(r_ent.start) == i_req.e);
        n_flags.ovl   = r_ent.valid && (END_W'(i_req.a) < w_end)
                        && (END_W'(r_ent.start) < i_req.e);
        n_cand        = START_W'(w_end - END_W'(i_req.size));
    end

    always_comb begin
        n_ent = r_ent;
        unique case (i_op)
            OP_NONE: begin
            end
            OP_SHRINK: begin
                if (i_tgt) n_ent.len = r_ent.len - i_req.size;
            end
            OP_REMOVE: begin
                if (i_mask) n_ent = i_hi;
            end
            OP_MERGE_BOTH: begin
                if (i_tgt) n_ent.len = r_ent.len + i_req.size + i_hi.len;
                else if (i_mask) n_ent = i_hi;
            end
            OP_MERGE_BELOW: begin
                if (i_tgt) n_ent.len = r_ent.len + i_req.size;
            end
            OP_MERGE_ABOVE: begin
                if (i_tgt) begin
                    n_ent.start = i_req.a;
                    n_ent.len   = r_ent.len + i_req.size;
                end
            end
            OP_INSERT: begin
                if (i_tgt) begin
                    n_ent.valid = 1'b1;
                    n_ent.start = i_req.a;
                    n_ent.len   = i_req.size;
                end else if (i_mask) begin
                    n_ent = i_lo;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_ent.valid <= P_FIRST && (i_init_len != '0);
            r_ent.start <= '0;
            r_ent.len   <= i_init_len;
        end else begin
            r_ent <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmp) begin
            r_flags <= n_flags;
            r_cand  <= n_cand;
        end
    end

    assign o_ent   = r_ent;
    assign o_flags = r_flags;
    assign o_cand  = r_cand;

endmodule

[design/first_fit_extent_allocator.sv]
// Top level of the first-fit extent allocator: request FSM, decision logic
// and the row of ffea_cell slots. Depends on ffea_pkg and ffea_cell.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  request   | start / busy              | i_kind, i_size_blocks, i_offset_blocks
//  result    | o_result_strobe (1 cycle) | o_status, o_alloc_offset,
//            |                           | o_phys_addr, o_free_total
//  config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// A request steps through S_CMP, S_DEC and S_UPD: compare in every slot,
// first-fit / neighbor decision over the slot flags, then one shift or
// update step of the row. The strobe is registered from S_UPD;
// busy drops in the strobe cycle, so a new request may be accepted there.
// Synchronous reset loads one extent covering the pool; no clearing pass.
// The receiver cannot stall the result.
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS     = 64,
    parameter int POOL_BLOCKS_MAX = 4096,
    parameter int BLOCK_BYTES     = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [ffea_pkg::LEN_W-1:0]    i_size_blocks,
    input  logic [ffea_pkg::START_W-1:0]  i_offset_blocks,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_result_strobe,
    output logic [1:0]                    o_status,
    output logic [ffea_pkg::START_W-1:0]  o_alloc_offset,
    output logic [31:0]                   o_phys_addr,
    output logic [ffea_pkg::LEN_W-1:0]    o_free_total
);
    import ffea_pkg::*;

    localparam int N = MAX_EXTENTS;
    localparam int LP_CAP = (POOL_BLOCKS_MAX > 8191) ? 8191 : POOL_BLOCKS_MAX;
    localparam logic [LEN_W-1:0] LP_CAP_V    = LEN_W'(LP_CAP);
    localparam logic [LEN_W-1:0] LP_POOL_RST = LEN_W'((4096 > LP_CAP) ? LP_CAP : 4096);
    localparam logic [N-1:0]     LP_ONE      = {{(N-1){1'b0}}, 1'b1};
    localparam logic [31:0]      LP_BB       = 32'(BLOCK_BYTES);

    t_state r_state, n_state;

    logic               r_kind;
    t_req               r_req;
    logic [LEN_W-1:0]   r_pool;
    logic [31:0]        r_base;
    logic [LEN_W-1:0]   r_sum;
    t_op                r_op;
    logic [N-1:0]       r_tgt, r_mask;
    t_status            r_status;
    logic [START_W-1:0] r_off;

    logic               r_strobe;
    t_status            r_status_o;
    logic [START_W-1:0] r_off_o;
    logic [31:0]        r_phys;
    logic [LEN_W-1:0]   r_total;

    logic               w_accept, w_pool_wr, w_init;
    logic [LEN_W-1:0]   w_cfg_pool, w_init_len;
    t_op                w_cell_op;

    t_ent               w_ent   [N];
    t_flags             w_flag  [N];
    logic [START_W-1:0] w_cand  [N];

    logic [N-1:0] w_valid, w_fit, w_eq, w_lt, w_endeq, w_steq, w_ovl;
    logic [N-1:0] w_oh, w_rm_mask, w_ispos, w_posm1;
    logic [START_W-1:0] w_off;
    logic         w_below, w_above, w_bad;

    t_op                d_op;
    logic [N-1:0]       d_tgt, d_mask;
    t_status            d_status;
    logic [START_W-1:0] d_off;

    assign w_accept   = start && !busy;
    assign w_pool_wr  = i_cfg_we && (i_cfg_idx == CFG_POOL_BLOCKS);
    assign w_cfg_pool = (i_cfg_data[LEN_W-1:0] > LP_CAP_V) ? LP_CAP_V
                                                           : i_cfg_data[LEN_W-1:0];
    assign w_init     = w_pool_wr;
    assign w_init_len = !i_rst_n ? LP_POOL_RST : w_cfg_pool;
    assign w_cell_op  = (r_state == S_UPD) ? r_op : OP_NONE;

    // slot row
    for (genvar g = 0; g < N; g++) begin : g_cell
        t_ent w_lo, w_hi;
        if (g == 0) begin : g_lo0
            assign w_lo = '0;
        end else begin : g_lo
            assign w_lo = w_ent[g-1];
        end
        if (g == N-1) begin : g_hiN
            assign w_hi = '0;
        end else begin : g_hi
            assign w_hi = w_ent[g+1];
        end
        ffea_cell #(.P_FIRST(g == 0)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_init     (w_init),
            .i_init_len (w_init_len),
            .i_cmp      (r_state == S_CMP),
            .i_req      (r_req),
            .i_op       (w_cell_op),
            .i_tgt      (r_tgt[g]),
            .i_mask     (r_mask[g]),
            .i_lo       (w_lo),
            .i_hi       (w_hi),
            .o_ent      (w_ent[g]),
            .o_flags    (w_flag[g]),
            .o_cand     (w_cand[g])
        );
        assign w_valid[g] = w_flag[g].valid;
        assign w_fit[g]   = w_flag[g].ge;
        assign w_eq[g]    = w_flag[g].eqlen;
        assign w_lt[g]    = w_flag[g].lt;
        assign w_endeq[g] = w_flag[g].endeq;
        assign w_steq[g]  = w_flag[g].steq;
        assign w_ovl[g]   = w_flag[g].ovl;
    end

    // first fit and insert position
    assign w_oh      = w_fit & (~w_fit + LP_ONE);
    assign w_rm_mask = ~(w_oh - LP_ONE);
    assign w_ispos   = ~w_lt & {w_lt[N-2:0], 1'b1};
    assign w_posm1   = w_lt & ~{1'b0, w_lt[N-1:1]};
    assign w_below   = |(w_posm1 & w_endeq);
    assign w_above   = |(w_ispos & w_steq);
    assign w_bad     = (r_req.size == '0) || (r_req.e > END_W'(r_pool)) || (|w_ovl);

    always_comb begin
        w_off = '0;
        for (int i = 0; i < N; i++) begin
            w_off = w_off | (w_cand[i] & {START_W{w_oh[i]}});
        end
    end

    always_comb begin
        d_op     = OP_NONE;
        d_tgt    = '0;
        d_mask   = '0;
        d_status = ST_OK;
        d_off    = '0;
        if (r_kind == KIND_ALLOC) begin
            if (r_req.size == '0 || w_fit == '0) begin
                d_status = ST_NOSPACE;
            end else begin
                d_op   = (|(w_oh & w_eq)) ? OP_REMOVE : OP_SHRINK;
                d_tgt  = w_oh;
                d_mask = w_rm_mask;
                d_off  = w_off;
            end
        end else begin
            priority if (w_bad) begin
                d_status = ST_DOUBLE;
            end else if (w_below && w_above) begin
                d_op   = OP_MERGE_BOTH;
                d_tgt  = w_posm1;
                d_mask = ~w_lt;
            end else if (w_below) begin
                d_op  = OP_MERGE_BELOW;
                d_tgt = w_posm1;
            end else if (w_above) begin
                d_op  = OP_MERGE_ABOVE;
                d_tgt = w_ispos;
            end else if (w_valid[N-1]) begin
                d_status = ST_FULL;
            end else begin
                d_op   = OP_INSERT;
                d_tgt  = w_ispos;
                d_mask = ~w_lt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) n_state = S_CMP;
            end
            S_CMP:   n_state = S_DEC;
            S_DEC:   n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // request capture, decision and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool   <= LP_POOL_RST;
            r_base   <= '0;
            r_sum    <= LP_POOL_RST;
            r_op     <= OP_NONE;
            r_strobe <= 1'b0;
        end else begin
            if (w_pool_wr) begin
                r_pool <= w_cfg_pool;
                r_sum  <= w_cfg_pool;
            end
            if (i_cfg_we && i_cfg_idx == CFG_PHYS_BASE) r_base <= i_cfg_data;
            if (w_accept) begin
                r_kind     <= i_kind;
                r_req.a    <= i_offset_blocks;
                r_req.size <= i_size_blocks;
                r_req.e    <= END_W'(i_offset_blocks) + END_W'(i_size_blocks);
            end
            if (r_state == S_DEC) begin
                r_op     <= d_op;
                r_tgt    <= d_tgt;
                r_mask   <= d_mask;
                r_status <= d_status;
                r_off    <= d_off;
                if (d_status == ST_OK) begin
                    r_sum <= (r_kind == KIND_ALLOC) ? r_sum - r_req.size
                                                    : r_sum + r_req.size;
                end
            end
            r_strobe <= (r_state == S_UPD);
            if (r_state == S_UPD) begin
                r_status_o <= r_status;
                r_off_o    <= r_off;
                r_phys     <= (r_kind == KIND_ALLOC && r_status == ST_OK)
                              ? r_base + 32'(r_off) * LP_BB : '0;
                r_total    <= r_sum;
            end
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_status        = r_status_o;
    assign o_alloc_offset  = r_off_o;
    assign o_phys_addr     = r_phys;
    assign o_free_total    = r_total;

endmodule

[design/ffea_chk.sv]
// Port-level checks for first_fit_extent_allocator, bound to the top level.
// Depends on ffea_pkg.
module ffea_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_result_strobe,
    input logic [1:0]                    o_status,
    input logic [ffea_pkg::START_W-1:0]  o_alloc_offset,
    input logic [31:0]                   o_phys_addr
);
    import ffea_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_result_strobe)
        else $error("result strobe missing four cycles after request");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!busy ##1 !o_result_strobe))
        else $error("result strobe while busy or longer than one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_status != ST_OK) |->
            (o_alloc_offset == '0 && o_phys_addr == '0))
        else $error("failed request reports nonzero offset or address");

endmodule

bind first_fit_extent_allocator ffea_chk u_ffea_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_status        (o_status),
    .o_alloc_offset  (o_alloc_offset),
    .o_phys_addr     (o_phys_addr)
);

[sim/first_fit_extent_allocator_test.sv]
// Self-checking bench for first_fit_extent_allocator: a directed request table, then
// random alloc/free traffic, each result checked against an in-bench extent table model.
// Depends on ffea_pkg and the allocator RTL.
module first_fit_extent_allocator_test;
    import ffea_pkg::*;

    localparam int MAX_EXT     = 64;
    localparam int POOL_MAX    = 4096;
    localparam int BLK_BYTES   = 256;
    localparam int N_REQUESTS  = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_ERRS  = 10;

    // register indexes the block ignores
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] offset;
        logic [31:0]        phys;
        logic [LEN_W-1:0]   total;
    } t_outcome;

    typedef struct packed {
        bit                 is_cfg;
        logic [1:0]         idx;
        logic [31:0]        data;
        logic               kind;
        logic [LEN_W-1:0]   size;
        logic [START_W-1:0] offs;
        bit                 typed;
        t_outcome           want;
    } t_step;

    typedef struct {
        int lo;
        int len;
    } t_span;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 start           = 1'b0;
    logic                 i_kind          = KIND_ALLOC;
    logic [LEN_W-1:0]     i_size_blocks   = '0;
    logic [START_W-1:0]   i_offset_blocks = '0;
    logic                 i_cfg_we        = 1'b0;
    logic [1:0]           i_cfg_idx       = CFG_POOL_BLOCKS;
    logic [31:0]          i_cfg_data      = '0;
    logic                 busy;
    logic                 o_result_strobe;
    logic [1:0]           o_status;
    logic [START_W-1:0]   o_alloc_offset;
    logic [31:0]          o_phys_addr;
    logic [LEN_W-1:0]     o_free_total;

    // model of the free extent table
    int unsigned          pool_size;
    logic [31:0]          phys_base;
    logic [START_W-1:0]   ext_lo  [MAX_EXT];
    logic [LEN_W-1:0]     ext_len [MAX_EXT];
    int                   ext_cnt;
    int                   spare_blocks;

    t_outcome             pending[$];
    t_step                directed_ops[$];
    t_span                live[$];
    t_span                retired;
    bit                   have_retired = 1'b0;
    t_outcome             last_outcome;
    bit                   burst_mode = 1'b0;
    int                   sent = 0;
    int                   failures = 0;
    int                   cycle_count = 0;

    first_fit_extent_allocator #(
        .MAX_EXTENTS    (MAX_EXT),
        .POOL_BLOCKS_MAX(POOL_MAX),
        .BLOCK_BYTES    (BLK_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_size_blocks  (i_size_blocks),
        .i_offset_blocks(i_offset_blocks),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_strobe(o_result_strobe),
        .o_status       (o_status),
        .o_alloc_offset (o_alloc_offset),
        .o_phys_addr    (o_phys_addr),
        .o_free_total   (o_free_total)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void pool_rebuild();
        ext_lo[0]    = '0;
        ext_len[0]   = LEN_W'(pool_size);
        ext_cnt      = (pool_size != 0) ? 1 : 0;
        spare_blocks = pool_size;
    endfunction

    function automatic void drop_extent(int idx);
        for (int i = idx; i + 1 < ext_cnt; i++) begin
            ext_lo[i]  = ext_lo[i+1];
            ext_len[i] = ext_len[i+1];
        end
        ext_cnt--;
    endfunction

    // first fit, carved from the top of the extent
    function automatic t_status extent_alloc(int len, output int slot_lo);
        slot_lo = 0;
        if (len == 0) return ST_NOSPACE;
        for (int i = 0; i < ext_cnt; i++) begin
            if (ext_len[i] >= len) begin
                if (ext_len[i] > len) begin
                    ext_len[i] = LEN_W'(ext_len[i] - len);
                    slot_lo    = int'(ext_lo[i]) + int'(ext_len[i]);
                end else begin
                    slot_lo = int'(ext_lo[i]);
                    drop_extent(i);
                end
                spare_blocks -= len;
                return ST_OK;
            end
        end
        return ST_NOSPACE;
    endfunction

    function automatic t_status extent_release(int lo, int len);
        int hi;
        int pos;
        bit below;
        bit above;
        hi = lo + len;
        if (len == 0 || hi > pool_size) return ST_DOUBLE;
        for (int i = 0; i < ext_cnt; i++)
            if (lo < ext_lo[i] + ext_len[i] && ext_lo[i] < hi) return ST_DOUBLE;
        pos = 0;
        while (pos < ext_cnt && ext_lo[pos] < lo) pos++;
        below = pos > 0 && ext_lo[pos-1] + ext_len[pos-1] == lo;
        above = pos < ext_cnt && ext_lo[pos] == hi;
        if (below && above) begin
            ext_len[pos-1] = LEN_W'(ext_len[pos-1] + len + ext_len[pos]);
            drop_extent(pos);
        end else if (below) begin
            ext_len[pos-1] = LEN_W'(ext_len[pos-1] + len);
        end else if (above) begin
            ext_lo[pos]  = START_W'(lo);
            ext_len[pos] = LEN_W'(ext_len[pos] + len);
        end else begin
            if (ext_cnt >= MAX_EXT) return ST_FULL;
            for (int i = ext_cnt; i > pos; i--) begin
                ext_lo[i]  = ext_lo[i-1];
                ext_len[i] = ext_len[i-1];
            end
            ext_lo[pos]  = START_W'(lo);
            ext_len[pos] = LEN_W'(len);
            ext_cnt++;
        end
        spare_blocks += len;
        return ST_OK;
    endfunction

    function automatic t_outcome predict_outcome(logic kind, int len, int lo);
        t_outcome o;
        int slot_lo;
        o = '0;
        if (kind == KIND_ALLOC) begin
            o.status = extent_alloc(len, slot_lo);
            if (o.status == ST_OK) begin
                o.offset = START_W'(slot_lo);
                o.phys   = phys_base + 32'(slot_lo) * BLK_BYTES;
            end
        end else begin
            o.status = extent_release(lo, len);
        end
        o.total = LEN_W'(spare_blocks);
        return o;
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= SHOWN_ERRS) $display("ERROR @%0d: %s", cycle_count, msg);
    endfunction

    function automatic t_step row_check(logic kind, int len, int lo, t_status st, int aoff,
                                        logic [31:0] phys, int total);
        t_step s;
        s              = '0;
        s.kind         = kind;
        s.size         = LEN_W'(len);
        s.offs         = START_W'(lo);
        s.typed        = 1'b1;
        s.want.status  = st;
        s.want.offset  = START_W'(aoff);
        s.want.phys    = phys;
        s.want.total   = LEN_W'(total);
        return s;
    endfunction

    function automatic t_step row_req(logic kind, int len, int lo);
        t_step s;
        s      = '0;
        s.kind = kind;
        s.size = LEN_W'(len);
        s.offs = START_W'(lo);
        return s;
    endfunction

    function automatic t_step row_cfg(logic [1:0] idx, logic [31:0] data);
        t_step s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_outcome exp_r;
        if (i_rst_n && o_result_strobe === 1'b1) begin
            if (pending.size() == 0) begin
                note_failure($sformatf("result with no request pending: status %0d off %0d",
                                       o_status, o_alloc_offset));
            end else begin
                exp_r = pending.pop_front();
                if (o_status !== exp_r.status || o_alloc_offset !== exp_r.offset ||
                    o_phys_addr !== exp_r.phys || o_free_total !== exp_r.total)
                    note_failure($sformatf(
                        "expected status %0d off %0d phys %h total %0d, got %0d %0d %h %0d",
                        exp_r.status, exp_r.offset, exp_r.phys, exp_r.total,
                        o_status, o_alloc_offset, o_phys_addr, o_free_total));
            end
        end
    end

    task automatic idle_sender();
        int r;
        int gap;
        gap = 0;
        if (!burst_mode) begin
            r = $urandom_range(0, 99);
            if (r < 55) gap = 0;
            else if (r < 92) gap = $urandom_range(1, 3);
            else gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(logic kind, int len, int lo, bit typed, t_outcome want);
        logic [LEN_W-1:0]   len_v;
        logic [START_W-1:0] lo_v;
        len_v           = LEN_W'(len);
        lo_v            = START_W'(lo);
        i_kind          <= kind;
        i_size_blocks   <= len_v;
        i_offset_blocks <= lo_v;
        start           <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        last_outcome = predict_outcome(kind, int'(len_v), int'(lo_v));
        pending.push_back(typed ? want : last_outcome);
        sent++;
        idle_sender();
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        int v;
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POOL_BLOCKS) begin
            v = int'(data[LEN_W-1:0]);
            pool_size = (v > POOL_MAX) ? POOL_MAX : v;
            pool_rebuild();
            live.delete();
            have_retired = 1'b0;
        end else if (idx == CFG_PHYS_BASE) begin
            phys_base = data;
        end
    endtask

    // whole pool taken, then freed back in separated pieces until the table overflows
    task automatic fragment_pool();
        int stride;
        int k;
        int j;
        int tmp;
        int piece_len [66];
        int order [66];
        write_reg(CFG_POOL_BLOCKS, ($urandom & ~32'h1FFF) | POOL_MAX);
        send_request(KIND_ALLOC, POOL_MAX, $urandom, 1'b0, '0);
        stride = $urandom_range(2, 60);
        for (k = 0; k < 66; k++) begin
            order[k]     = k;
            piece_len[k] = $urandom_range(1, stride - 1);
        end
        for (k = 65; k > 0; k--) begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (k = 0; k < 66; k++)
            send_request(KIND_FREE, piece_len[order[k]], order[k] * stride, 1'b0, '0);
        // fill holes: merges still succeed with a full table
        repeat (6) begin
            k = $urandom_range(0, 64);
            send_request(KIND_FREE, stride - piece_len[k], k * stride + piece_len[k],
                         1'b0, '0);
        end
        repeat ($urandom_range(10, 20))
            send_request(KIND_ALLOC, $urandom_range(1, stride), $urandom, 1'b0, '0);
    endtask

    task automatic churn_pool(int n_items);
        int r;
        int i;
        int sz;
        t_span s;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 45 || (r < 85 && live.size() == 0)) begin
                i = $urandom_range(0, 19);
                if (i < 12) sz = $urandom_range(1, 8);
                else if (i < 17) sz = $urandom_range(1, 128);
                else if (i < 19) sz = $urandom_range(1, (pool_size > 0) ? pool_size : 1);
                else sz = $urandom_range(0, 8191);
                send_request(KIND_ALLOC, sz, $urandom, 1'b0, '0);
                if (last_outcome.status == ST_OK)
                    live.push_back('{int'(last_outcome.offset), sz});
            end else if (r < 85) begin
                i = $urandom_range(0, live.size() - 1);
                s = live[i];
                send_request(KIND_FREE, s.len, s.lo, 1'b0, '0);
                if (last_outcome.status == ST_OK) begin
                    live.delete(i);
                    retired      = s;
                    have_retired = 1'b1;
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: send_request(KIND_FREE, $urandom_range(0, 16), $urandom, 1'b0, '0);
                    1: send_request(KIND_FREE, $urandom_range(0, 8191), $urandom, 1'b0, '0);
                    2: begin
                        if (have_retired)
                            send_request(KIND_FREE, retired.len, retired.lo, 1'b0, '0);
                        else
                            send_request(KIND_FREE, $urandom_range(1, 4), $urandom, 1'b0, '0);
                    end
                    default: send_request(KIND_ALLOC, 0, $urandom, 1'b0, '0);
                endcase
            end
            if ($urandom_range(0, 59) == 0) wait_idle();
        end
    endtask

    initial begin
        t_step row;
        int phase;
        int pool_val;
        logic [31:0] base_val;
        pool_size = POOL_MAX;
        phys_base = '0;
        pool_rebuild();

        directed_ops.push_back(row_check(KIND_ALLOC, 0,    0,    ST_NOSPACE, 0,    0, 4096));
        directed_ops.push_back(row_check(KIND_ALLOC, 8191, 4095, ST_NOSPACE, 0,    0, 4096));
        directed_ops.push_back(row_check(KIND_ALLOC, 4096, 0,    ST_OK,      0,    0, 0));
        directed_ops.push_back(row_check(KIND_ALLOC, 1,    0,    ST_NOSPACE, 0,    0, 0));
        directed_ops.push_back(row_check(KIND_FREE,  0,    0,    ST_DOUBLE,  0,    0, 0));
        directed_ops.push_back(row_check(KIND_FREE,  2,    4095, ST_DOUBLE,  0,    0, 0));
        directed_ops.push_back(row_check(KIND_FREE,  5,    10,   ST_OK,      0,    0, 5));
        directed_ops.push_back(row_check(KIND_FREE,  5,    5,    ST_OK,      0,    0, 10));
        directed_ops.push_back(row_check(KIND_FREE,  4,    20,   ST_OK,      0,    0, 14));
        directed_ops.push_back(row_check(KIND_FREE,  5,    15,   ST_OK,      0,    0, 19));
        directed_ops.push_back(row_check(KIND_FREE,  4,    22,   ST_DOUBLE,  0,    0, 19));
        directed_ops.push_back(row_check(KIND_FREE,  1,    5,    ST_DOUBLE,  0,    0, 19));
        directed_ops.push_back(row_check(KIND_FREE,  5,    4091, ST_OK,      0,    0, 24));
        directed_ops.push_back(row_check(KIND_FREE,  3,    24,   ST_OK,      0,    0, 27));
        directed_ops.push_back(row_check(KIND_ALLOC, 22,   4095, ST_OK,      5, 1280, 5));
        directed_ops.push_back(row_check(KIND_ALLOC, 2,    0,    ST_OK, 4094, 32'h000F_FE00, 3));
        directed_ops.push_back(row_cfg(CFG_PHYS_BASE, 32'hFFFF_FF00));
        directed_ops.push_back(row_req(KIND_ALLOC, 3, 0));
        directed_ops.push_back(row_cfg(CFG_POOL_BLOCKS, 32'h0000_1FFF));
        directed_ops.push_back(row_check(KIND_ALLOC, 1, 0, ST_OK, 4095, 32'h000F_FE00, 4095));
        directed_ops.push_back(row_cfg(CFG_SPARE_A, 32'hFFFF_FFFF));
        directed_ops.push_back(row_cfg(CFG_SPARE_B, 32'h0000_0000));
        directed_ops.push_back(row_check(KIND_ALLOC, 4095, 0, ST_OK, 0, 32'hFFFF_FF00, 0));
        directed_ops.push_back(row_cfg(CFG_POOL_BLOCKS, 32'hFFFF_E000));
        directed_ops.push_back(row_check(KIND_ALLOC, 1,    0,    ST_NOSPACE, 0,    0, 0));
        directed_ops.push_back(row_check(KIND_FREE,  1,    0,    ST_DOUBLE,  0,    0, 0));
        directed_ops.push_back(row_cfg(CFG_POOL_BLOCKS, 32'd1));
        directed_ops.push_back(row_check(KIND_FREE,  1,    0,    ST_DOUBLE,  0,    0, 1));
        directed_ops.push_back(row_check(KIND_ALLOC, 1,    0,    ST_OK, 0, 32'hFFFF_FF00, 0));
        directed_ops.push_back(row_check(KIND_FREE,  1,    0,    ST_OK,      0,    0, 1));
        directed_ops.push_back(row_cfg(CFG_PHYS_BASE, 32'h8000_0001));
        directed_ops.push_back(row_cfg(CFG_POOL_BLOCKS, 32'd300));
        directed_ops.push_back(row_req(KIND_ALLOC, 17, 12'hAAA));
        directed_ops.push_back(row_req(KIND_FREE, 17, 283));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[n]) begin
            row = directed_ops[n];
            if (row.is_cfg) write_reg(row.idx, row.data);
            else send_request(row.kind, int'(row.size), int'(row.offs), row.typed, row.want);
        end

        phase = 0;
        while (sent < N_REQUESTS) begin
            phase++;
            burst_mode = ($urandom_range(0, 3) == 0);
            if (phase % 6 == 2) begin
                fragment_pool();
            end else begin
                case ($urandom_range(0, 11))
                    0:          pool_val = 0;
                    1:          pool_val = 1;
                    2:          pool_val = $urandom_range(POOL_MAX, 8191);
                    3, 4:       pool_val = POOL_MAX;
                    5, 6, 7, 8: pool_val = $urandom_range(16, 300);
                    default:    pool_val = $urandom_range(2, POOL_MAX - 1);
                endcase
                case ($urandom_range(0, 5))
                    0:       base_val = 32'h0000_0000;
                    1:       base_val = 32'hFFFF_FFFF;
                    default: base_val = $urandom;
                endcase
                if ($urandom_range(0, 1)) begin
                    write_reg(CFG_POOL_BLOCKS, ($urandom & ~32'h1FFF) | pool_val);
                    write_reg(CFG_PHYS_BASE, base_val);
                end else begin
                    write_reg(CFG_PHYS_BASE, base_val);
                    write_reg(CFG_POOL_BLOCKS, ($urandom & ~32'h1FFF) | pool_val);
                end
                churn_pool((pool_size == 0) ? 6 : $urandom_range(20, 60));
            end
        end

        burst_mode = 1'b0;
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (failures == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule
